// ----- sv/mexp_pkg.sv -----
// shared constants and types for the modular exponentiation core
`timescale 1ns / 1ps
package mexp_pkg;
    localparam int WIDTH = 32;
    localparam int MW = 31;
    localparam int CW = MW + 1;
    localparam int EW = 31;
    localparam int NCELL = CW;
    localparam logic [0:0] REG_MODULUS = 1'b0;
    localparam logic [0:0] REG_EXPONENT = 1'b1;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RED = 2'd1;
    localparam logic [1:0] ST_MUL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    typedef struct packed {
        logic [CW-1:0] acc;
        logic [CW-1:0] rem;
        logic          live;
    } t_link;
endpackage

// ----- sv/mexp_cell.sv -----
// one cell of the shift-and-subtract reduction chain
`timescale 1ns / 1ps
module mexp_cell
    import mexp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [MW-1:0] i_mod,
    input  t_link         i_link,
    input  logic          i_bit,
    input  logic          i_add,
    input  logic [MW-1:0] i_addend,
    output t_link         o_link
);
    logic [CW+1:0] w_sum;
    logic [CW+1:0] w_red;
    t_link         n_link;
    always_comb begin
        w_sum = {i_link.rem, 1'b0} + {{(CW+1){1'b0}}, i_bit}
              + (i_add ? {3'b000, i_addend} : '0);
        w_red = w_sum;
        if (w_red >= {3'b000, i_mod}) w_red = w_red - {3'b000, i_mod};
        if (w_red >= {3'b000, i_mod}) w_red = w_red - {3'b000, i_mod};
        n_link.acc  = i_link.acc;
        n_link.rem  = w_red[CW-1:0];
        n_link.live = i_link.live;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_link.live <= 1'b0;
        end else begin
            o_link.live <= n_link.live;
        end
        o_link.acc <= n_link.acc;
        o_link.rem <= n_link.rem;
    end
endmodule

// ----- sv/mexp_modmul.sv -----
// bit-serial modular multiplier on a chain of reduction cells
`timescale 1ns / 1ps
module mexp_modmul
    import mexp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_mod,
    input  logic [CW-1:0] i_x,
    input  logic [MW-1:0] i_y,
    input  logic          i_add,
    output logic          o_done,
    output logic [MW-1:0] o_prod
);
    // each cell handles one multiplier bit, msb first
    t_link w_link [NCELL+1];
    logic [CW-1:0] r_x;
    logic [MW-1:0] r_y;
    logic          r_add;
    assign w_link[0].acc  = '0;
    assign w_link[0].rem  = '0;
    assign w_link[0].live = i_start;
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_add <= i_add;
        end
    end
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic          w_xb;
        logic          w_ad;
        logic [MW-1:0] w_y;
        assign w_xb = (g == 0) ? i_x[CW-1] : r_x[CW-1-g];
        assign w_ad = (g == 0) ? i_add : r_add;
        assign w_y  = (g == 0) ? i_y : r_y;
        mexp_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_mod    (i_mod),
            .i_link   (w_link[g]),
            .i_bit    (w_xb & ~w_ad),
            .i_add    (w_ad),
            .i_addend (w_y & {MW{w_xb}}),
            .o_link   (w_link[g+1])
        );
    end
    assign o_done = w_link[NCELL].live;
    assign o_prod = w_link[NCELL].rem[MW-1:0];
endmodule

// ----- sv/mexp_mult.sv -----
// shift-add modular multiply unit, one multiplier bit per cycle
`timescale 1ns / 1ps
module mexp_mult
    import mexp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_mod,
    input  logic [MW-1:0] i_a,
    input  logic [MW-1:0] i_b,
    output logic          o_done,
    output logic [MW-1:0] o_prod
);
    logic [MW-1:0] r_a, r_b, r_p;
    logic [4:0]    r_cnt;
    logic          r_busy, r_done;
    logic [CW:0]   w_t;
    logic [CW:0]   w_u;
    always_comb begin
        w_t = {r_p, 1'b0};
        if (w_t >= {2'b00, i_mod}) w_t = w_t - {2'b00, i_mod};
        w_u = w_t + (r_a[MW-1] ? {2'b00, r_b} : '0);
        if (w_u >= {2'b00, i_mod}) w_u = w_u - {2'b00, i_mod};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            r_a <= {r_a[MW-2:0], 1'b0};
            r_p <= w_u[MW-1:0];
        end
    end
    assign o_done = r_done;
    assign o_prod = r_p;
endmodule

// ----- sv/modular_exponentiation_core.sv -----
// top level: right-to-left square-and-multiply modular exponentiation
//  channel | direction | handshake     | payload
//  in      | input     | valid / stall | base (32 bits)
//  out     | output    | valid / stall | power_mod (31 bits)
//  cfg     | input     | valid / ready | index (1 bit), data (31 bits)
// base is reduced through a 32-cell chain of registered reduction cells
// each exponent bit costs two modular products run in parallel on two
// shift-add multipliers
// the next beat can be accepted in the cycle after the result is registered
// synchronous active-low reset restores modulus 1, exponent 1
// a result waits in the output register while the next beat is accepted
`timescale 1ns / 1ps
module modular_exponentiation_core
    import mexp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_base,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [MW-1:0]    o_power_mod,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [0:0]       i_cfg_index,
    input  logic [MW-1:0]    i_cfg_data
);
    logic [MW-1:0] r_mod, r_exp, r_e, r_sq, r_acc, r_out;
    logic [1:0]    r_st;
    logic [4:0]    r_bit;
    logic          r_ov, r_red_go, r_mul_go;
    logic          r_top;
    logic [MW-1:0] w_m;
    logic          w_red_done, w_sq_done, w_ac_done;
    logic [MW-1:0] w_red, w_sq, w_ac;
    logic          w_acc_in;

    assign w_m = (r_mod == '0) ? MW'(1) : r_mod;
    assign o_cfg_ready = 1'b1;
    assign w_acc_in = i_valid && !o_stall;
    assign o_stall = (r_st != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MW'(1);
            r_exp <= MW'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODULUS:  r_mod <= i_cfg_data;
                REG_EXPONENT: r_exp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mexp_modmul u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_red_go),
        .i_mod   (w_m),
        .i_x     ({r_top, r_acc}),
        .i_y     ('0),
        .i_add   (1'b0),
        .o_done  (w_red_done),
        .o_prod  (w_red)
    );

    mexp_mult u_sq (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_mul_go), .i_mod (w_m),
        .i_a (r_sq), .i_b (r_sq), .o_done (w_sq_done), .o_prod (w_sq)
    );
    mexp_mult u_ac (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_mul_go), .i_mod (w_m),
        .i_a (r_acc), .i_b (r_sq), .o_done (w_ac_done), .o_prod (w_ac)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_ov     <= 1'b0;
            r_red_go <= 1'b0;
            r_mul_go <= 1'b0;
        end else begin
            r_red_go <= 1'b0;
            r_mul_go <= 1'b0;
            if (r_ov && !i_stall && r_st != ST_DONE) r_ov <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (w_acc_in) begin
                        r_st     <= ST_RED;
                        r_red_go <= 1'b1;
                    end
                end
                ST_RED: begin
                    if (w_red_done) begin
                        r_sq     <= w_red;
                        r_acc    <= (w_m == MW'(1)) ? '0 : MW'(1);
                        r_bit    <= '0;
                        r_e      <= r_exp;
                        r_st     <= ST_MUL;
                        r_mul_go <= 1'b1;
                    end
                end
                ST_MUL: begin
                    if (w_sq_done && w_ac_done) begin
                        r_sq  <= w_sq;
                        if (r_e[0]) r_acc <= w_ac;
                        r_e   <= r_e >> 1;
                        r_bit <= r_bit + 5'd1;
                        if (r_bit == 5'(EW - 1)) r_st <= ST_DONE;
                        else r_mul_go <= 1'b1;
                    end
                end
                ST_DONE: begin
                    if (!r_ov || !i_stall) begin
                        r_out <= (r_exp == '0) ? MW'(1) : r_acc;
                        r_ov  <= 1'b1;
                        r_st  <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
        if (w_acc_in) r_acc <= i_base[MW-1:0];
    end

    // base enters the reduction chain through the accumulator slot
    always_ff @(posedge i_clk) begin
        if (w_acc_in) r_top <= i_base[WIDTH-1];
    end

    assign o_valid     = r_ov;
    assign o_power_mod = r_out;
endmodule

// ----- sv/mexp_checker.sv -----
// port-level checker for the modular exponentiation core
`timescale 1ns / 1ps
module mexp_checker
    import mexp_pkg::*;
(
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input logic [MW-1:0] o_power_mod
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_power_mod))
        else $error("output beat dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second beat taken while busy");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind modular_exponentiation_core mexp_checker u_chk (.*);
